// ===== src/tpsv_pkg.sv =====
package tpsv_pkg;

    // patch kinds; a chosen layout uses the same codes
    typedef logic [3:0] t_kind;

    localparam t_kind KIND_BASE         = 4'd0;
    localparam t_kind KIND_LEFT         = 4'd1;
    localparam t_kind KIND_RIGHT        = 4'd2;
    localparam t_kind KIND_TOP          = 4'd3;
    localparam t_kind KIND_BOTTOM       = 4'd4;
    localparam t_kind KIND_LEFT_TOP     = 4'd5;
    localparam t_kind KIND_LEFT_BOTTOM  = 4'd6;
    localparam t_kind KIND_RIGHT_TOP    = 4'd7;
    localparam t_kind KIND_RIGHT_BOTTOM = 4'd8;

    // register index taken from the address word
    localparam logic REG_GRID_SIZE = 1'b0;

    localparam int GRID_W     = 9;
    localparam int PADDR_W    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;

    // last vertex index of each cell shape
    localparam logic [3:0] LAST_QUAD   = 4'd5;
    localparam logic [3:0] LAST_EDGE   = 4'd8;
    localparam logic [3:0] LAST_CORNER = 4'd11;

    // triangle lists, corner point per vertex, index 0 at the right
    localparam logic [11:0][2:0] TRI_QUAD = {
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd3, 3'd2, 3'd0, 3'd2, 3'd1, 3'd0
    };
    localparam logic [11:0][2:0] TRI_EDGE = {
        3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd3,
        3'd3, 3'd1, 3'd2, 3'd2, 3'd1, 3'd0
    };
    localparam logic [11:0][2:0] TRI_CORNER = {
        3'd5, 3'd2, 3'd0, 3'd2, 3'd4, 3'd1,
        3'd1, 3'd3, 3'd0, 3'd2, 3'd1, 3'd0
    };

    typedef struct packed {
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic [3:0] patch_kind;
    } t_cell_in;

    typedef struct packed {
        logic [9:0] vert_x;
        logic [9:0] vert_z;
        logic       last_vertex;
    } t_vert_out;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        t_kind      layout;
    } t_job;

    // front to queue
    typedef struct packed {
        logic push;
        t_job job;
    } t_q_push;

    // queue head to back
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    // corner point offsets of a layout: point p at [4p+3:4p], {dx, dz}
    function automatic logic [23:0] layout_points(t_kind layout);
        logic [23:0] pts;
        unique case (layout)
            KIND_BASE:         pts = 24'h008A20;
            KIND_LEFT:         pts = 24'h0081A2;
            KIND_RIGHT:        pts = 24'h0A2908;
            KIND_TOP:          pts = 24'h02068A;
            KIND_BOTTOM:       pts = 24'h08A420;
            KIND_LEFT_TOP:     pts = 24'hA20618;
            KIND_LEFT_BOTTOM:  pts = 24'h20814A;
            KIND_RIGHT_TOP:    pts = 24'h8A2960;
            KIND_RIGHT_BOTTOM: pts = 24'h08A492;
            default:           pts = 24'h008A20;
        endcase
        return pts;
    endfunction

endpackage

// ===== src/tpsv_front.sv =====
module tpsv_front import tpsv_pkg::*; #(
    parameter int GRID_MAX = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cell_in           i_in_data,
    input  logic               i_q_ready,
    output t_q_push            o_q_push
);

    logic [GRID_W-1:0] r_grid_size;
    logic [GRID_W-1:0] n_grid_size;
    logic [GRID_W-1:0] wr_val;
    logic              on_left;
    logic              on_right;
    logic              on_top;
    logic              on_bottom;
    logic              vside;
    logic              hside;
    t_kind             vkind;
    t_kind             hkind;
    t_kind             layout;

    // register write from the low GRID_W bits of pwdata, clamped into 1..GRID_MAX
    always_comb begin
        wr_val      = pwdata[GRID_W-1:0];
        n_grid_size = r_grid_size;
        if (psel && penable && pwrite && (paddr[2] == REG_GRID_SIZE)) begin
            if (wr_val == '0) begin
                n_grid_size = GRID_W'(1);
            end else if (32'(wr_val) > 32'(GRID_MAX)) begin
                n_grid_size = GRID_W'(GRID_MAX);
            end else begin
                n_grid_size = wr_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_W'(1);
        end else begin
            r_grid_size <= n_grid_size;
        end
    end

    assign prdata = (paddr[2] == REG_GRID_SIZE) ? {{(32-GRID_W){1'b0}}, r_grid_size} : '0;

    // border tests
    assign on_left   = (i_in_data.cell_col == 8'd0);
    assign on_bottom = (i_in_data.cell_row == 8'd0);
    assign on_right  = (({1'b0, i_in_data.cell_col} + 9'd1) == r_grid_size);
    assign on_top    = (({1'b0, i_in_data.cell_row} + 9'd1) == r_grid_size);

    // layout from patch kind and borders; corner kinds pick the vertical and horizontal sides they touch
    always_comb begin
        vside = 1'b0;
        hside = 1'b0;
        vkind = KIND_BASE;
        hkind = KIND_BASE;
        layout = KIND_BASE;
        unique case (i_in_data.patch_kind)
            KIND_LEFT:   layout = on_left   ? KIND_LEFT   : KIND_BASE;
            KIND_RIGHT:  layout = on_right  ? KIND_RIGHT  : KIND_BASE;
            KIND_TOP:    layout = on_top    ? KIND_TOP    : KIND_BASE;
            KIND_BOTTOM: layout = on_bottom ? KIND_BOTTOM : KIND_BASE;
            KIND_LEFT_TOP, KIND_LEFT_BOTTOM, KIND_RIGHT_TOP, KIND_RIGHT_BOTTOM: begin
                if ((i_in_data.patch_kind == KIND_LEFT_TOP) ||
                    (i_in_data.patch_kind == KIND_LEFT_BOTTOM)) begin
                    vside = on_left;
                    vkind = KIND_LEFT;
                end else begin
                    vside = on_right;
                    vkind = KIND_RIGHT;
                end
                if ((i_in_data.patch_kind == KIND_LEFT_TOP) ||
                    (i_in_data.patch_kind == KIND_RIGHT_TOP)) begin
                    hside = on_top;
                    hkind = KIND_TOP;
                end else begin
                    hside = on_bottom;
                    hkind = KIND_BOTTOM;
                end
                priority if (vside && hside) begin
                    layout = i_in_data.patch_kind;
                end else if (vside) begin
                    layout = vkind;
                end else if (hside) begin
                    layout = hkind;
                end else begin
                    layout = KIND_BASE;
                end
            end
            default: layout = KIND_BASE;
        endcase
    end

    assign o_in_ready          = i_q_ready;
    assign o_q_push.push       = i_in_valid && i_q_ready;
    assign o_q_push.job.col    = i_in_data.cell_col;
    assign o_q_push.job.row    = i_in_data.cell_row;
    assign o_q_push.job.layout = layout;

endmodule

// ===== src/tpsv_queue.sv =====
module tpsv_queue import tpsv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_ready,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_ready      = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> o_ready)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== src/tpsv_back.sv =====
module tpsv_back import tpsv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_vert_out o_out_data
);

    logic [3:0]  r_k;
    logic        r_out_valid;
    t_vert_out   r_out;
    logic [3:0]  last_idx;
    logic [2:0]  pt;
    logic [23:0] pts;
    logic [3:0]  off;
    logic        emit;
    logic        is_last;
    t_vert_out   vert;

    // shape of the cell and its triangle list
    always_comb begin
        if (i_head.job.layout == KIND_BASE) begin
            last_idx = LAST_QUAD;
            pt       = TRI_QUAD[r_k];
        end else if (i_head.job.layout <= KIND_BOTTOM) begin
            last_idx = LAST_EDGE;
            pt       = TRI_EDGE[r_k];
        end else begin
            last_idx = LAST_CORNER;
            pt       = TRI_CORNER[r_k];
        end
    end

    assign pts     = layout_points(i_head.job.layout);
    assign off     = pts[{pt, 2'b00} +: 4];
    assign is_last = (r_k == last_idx);
    assign emit    = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop   = emit && is_last;

    assign vert.vert_x      = {1'b0, i_head.job.col, 1'b0} + {8'd0, off[3:2]};
    assign vert.vert_z      = {1'b0, i_head.job.row, 1'b0} + {8'd0, off[1:0]};
    assign vert.last_vertex = is_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= vert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_k         <= is_last ? 4'd0 : r_k + 4'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (r_k <= last_idx))
        else $error("vertex counter past end of cell");

    a_k_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && is_last) |=> (r_k == 4'd0))
        else $error("counter did not restart after last vertex");

    a_k_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !is_last) |=> (r_k == $past(r_k) + 4'd1))
        else $error("counter skipped a vertex");

endmodule

// ===== src/terrain_patch_stitch_vertex_gen_unit.sv =====
// channel   dir  handshake                  payload
// ------    ---  ---------                  -------
// in        in   i_in_valid / o_in_ready    i_in_data  (t_cell_in: cell_col, cell_row, patch_kind)
// out       out  o_out_valid / i_out_ready  o_out_data (t_vert_out: vert_x, vert_z, last_vertex)
// apb cfg   in   psel, penable, pwrite      paddr, pwdata, prdata; pready tied high
//
// one word per cell in, 6, 9 or 12 vertex words out, one per cycle from the back sequencer unless out stalls
// cells follow each other with no gap while the next one is queued and out does not stall
// front classifies in the accept cycle, a four-entry queue decouples it from the back
// synchronous active-low reset clears grid_size to 1, the queue and the output valid flag
// out stalls hold the output register; input stalls only when the queue is full
module terrain_patch_stitch_vertex_gen_unit import tpsv_pkg::*; #(
    parameter int GRID_MAX = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // cell words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cell_in           i_in_data,
    // vertex words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_vert_out          o_out_data
);

    t_q_push q_push;
    t_q_head q_head;
    logic    q_ready;
    logic    q_pop;

    assign pready = 1'b1;

    // classify each cell against the borders and pick its layout
    tpsv_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push)
    );

    // short job queue between classification and emission
    tpsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // walk the triangle list, one vertex word per cycle unless the output stalls or the queue is empty
    tpsv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
